// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl of the character packer
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("concurrent assertion failed");

// same-cycle implication, antecedent and consequent given apart
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concurrent implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concurrent next-cycle implication failed");

`endif

// File: rtl/core/sbcp_pkg.sv
// shared widths, code points and the character map of the packer
// no dependencies; used by sbcp_accum and six_bit_char_packer
`default_nettype none

package sbcp_pkg;

    localparam int CHAR_W = 8;
    localparam int CODE_W = 6;
    localparam int WORD_W = 60;
    localparam int CNT_W  = 4;

    // codes of the character set: unknown, letters and punctuation
    localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 6'd0;
    localparam logic [CODE_W-1:0] CODE_LOWER_A  = 6'd1;
    localparam logic [CODE_W-1:0] CODE_SPACE    = 6'd27;
    localparam logic [CODE_W-1:0] CODE_COMMA    = 6'd28;
    localparam logic [CODE_W-1:0] CODE_PERIOD   = 6'd29;
    localparam logic [CODE_W-1:0] CODE_QUESTION = 6'd30;
    localparam logic [CODE_W-1:0] CODE_BANG     = 6'd31;
    localparam logic [CODE_W-1:0] CODE_NEWLINE  = 6'd32;
    localparam logic [CODE_W-1:0] CODE_UPPER_A  = 6'd33;

    // ascii bytes of interest
    localparam logic [CHAR_W-1:0] ASC_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] ASC_LOWER_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] ASC_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] ASC_UPPER_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] ASC_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] ASC_COMMA    = 8'h2c;
    localparam logic [CHAR_W-1:0] ASC_PERIOD   = 8'h2e;
    localparam logic [CHAR_W-1:0] ASC_QUESTION = 8'h3f;
    localparam logic [CHAR_W-1:0] ASC_BANG     = 8'h21;
    localparam logic [CHAR_W-1:0] ASC_NEWLINE  = 8'h0a;

    // one finished word
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] word;
        logic              final_word;
    } t_word;

    function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off_lower;
        logic [CHAR_W-1:0] off_upper;
        logic [CODE_W-1:0] code;
        off_lower = c - ASC_LOWER_A;
        off_upper = c - ASC_UPPER_A;
        if (c >= ASC_LOWER_A && c <= ASC_LOWER_Z) begin
            code = CODE_LOWER_A + off_lower[CODE_W-1:0];
        end else if (c >= ASC_UPPER_A && c <= ASC_UPPER_Z) begin
            code = CODE_UPPER_A + off_upper[CODE_W-1:0];
        end else begin
            case (c)
                ASC_SPACE:    code = CODE_SPACE;
                ASC_COMMA:    code = CODE_COMMA;
                ASC_PERIOD:   code = CODE_PERIOD;
                ASC_QUESTION: code = CODE_QUESTION;
                ASC_BANG:     code = CODE_BANG;
                ASC_NEWLINE:  code = CODE_NEWLINE;
                default:      code = CODE_UNKNOWN;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/six_bit_char_packer.sv
// top level of the six-bit character packer: input register, accumulator, output register
// depends on sbcp_pkg, sbcp_accum and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Packs a stream of 8-bit characters, one per item, into 60-bit words of
// 6-bit codes (a-z 1..26, space , . ? ! newline 27..32, A-Z 33..58, any
// other byte 0). The first character of a word lands in the most significant
// used code slot and the word is right-justified. A word leaves after
// CHARS_PER_WORD characters or on the character marked with tlast, carrying
// its character count and a final flag on tlast. One item is taken every
// cycle unless a closing character waits for a stalled output register; a word
// becomes valid on the master side after its closing character has passed the
// input register, where it is held while the lookup and shift run, and has been
// taken into the output register together with the accumulator update.
// The output register holds a word while the sink stalls, and input keeps
// flowing as long as the pending character does not itself close a word.
module six_bit_char_packer #(
    parameter int CHARS_PER_WORD = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] character
    input  wire         s_axis_tlast,   // end_of_string
    // master side
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [59:0] packed_word, [63:60] char_count
    output logic        m_axis_tlast    // final_word
);

    // input register
    logic                        r_in_valid;
    logic [sbcp_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_last;

    // output register
    logic            r_out_valid;
    sbcp_pkg::t_word r_out;

    logic            s_accept;
    logic            out_free;
    logic            step;
    logic            emit;
    sbcp_pkg::t_word word;

    // the pending character may move on unless it closes a word that has nowhere to go
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!emit || out_free);
    assign s_axis_tready = !r_in_valid || step;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    sbcp_accum #(
        .CHARS_PER_WORD (CHARS_PER_WORD)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_emit  (emit),
        .o_word  (word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.count, r_out.word};
    assign m_axis_tlast  = r_out.final_word;

    // a word holds at least one and at most a full set of characters
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, m_axis_tvalid,
        (r_out.count != '0) && (r_out.count <= sbcp_pkg::CNT_W'(CHARS_PER_WORD)))
    // a word leaves only when full or when the string ends
    `ASSERT_IMPL(a_word_closed, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tlast || (r_out.count == sbcp_pkg::CNT_W'(CHARS_PER_WORD)))
    // a character stalled in the input register is not dropped
    `ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !step, r_in_valid)
    // a closing character never overwrites a word that is still waiting
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, step && emit, out_free)

endmodule

`default_nettype wire

// File: rtl/core/sbcp_accum.sv
// word accumulator: codes one character and shifts it into the word
// depends on sbcp_pkg
`default_nettype none

module sbcp_accum #(
    parameter int CHARS_PER_WORD = 10
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  wire [sbcp_pkg::CHAR_W-1:0] i_char,
    input  wire                        i_last,
    output logic                       o_emit,
    output sbcp_pkg::t_word            o_word
);

    localparam logic [sbcp_pkg::CNT_W-1:0] FULL_CNT = sbcp_pkg::CNT_W'(CHARS_PER_WORD);

    logic [sbcp_pkg::WORD_W-1:0] r_acc, n_acc;
    logic [sbcp_pkg::CNT_W-1:0]  r_fill, n_fill;
    logic [sbcp_pkg::CODE_W-1:0] code;

    always_comb begin
        code   = sbcp_pkg::char_code(i_char);
        n_acc  = {r_acc[sbcp_pkg::WORD_W-sbcp_pkg::CODE_W-1:0], code};
        n_fill = r_fill + 1'b1;
        o_emit = (n_fill >= FULL_CNT) || i_last;
        o_word.word       = n_acc;
        o_word.count      = n_fill;
        o_word.final_word = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
        end else if (i_step) begin
            // a finished word restarts the accumulator
            if (o_emit) begin
                r_acc  <= '0;
                r_fill <= '0;
            end else begin
                r_acc  <= n_acc;
                r_fill <= n_fill;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/six_bit_char_packer_tb.sv
// testbench of six_bit_char_packer: streams characters in, checks every packed word out
// depends on sbcp_pkg and the six_bit_char_packer rtl; self-contained otherwise
`timescale 1ns / 100ps

module six_bit_char_packer_tb;

    localparam int WORD_CHARS = 10;
    localparam int LAST_ITEMS = 1875;   // no new string starts once this many items are in
    localparam int CALM_AFTER = 1650;   // strings begun from here on see no idling on either side
    localparam int DRAIN_MAX  = 2000;   // cycles allowed for outstanding words at the end

    // packs characters the way the block should and checks the words it emits
    class word_scoreboard;
        bit [sbcp_pkg::WORD_W-1:0] acc;
        bit [sbcp_pkg::CNT_W-1:0]  fill;
        sbcp_pkg::t_word           expected_words[$];
        int                        mismatches;

        function new();
            acc = '0;
            fill = '0;
            mismatches = 0;
        endfunction

        // 6-bit code of one character byte, zero for anything outside the set
        function bit [sbcp_pkg::CODE_W-1:0] six_bit_code(bit [sbcp_pkg::CHAR_W-1:0] ch);
            if (ch >= sbcp_pkg::ASC_LOWER_A && ch <= sbcp_pkg::ASC_LOWER_Z)
                return sbcp_pkg::CODE_LOWER_A
                       + sbcp_pkg::CODE_W'(ch - sbcp_pkg::ASC_LOWER_A);
            if (ch >= sbcp_pkg::ASC_UPPER_A && ch <= sbcp_pkg::ASC_UPPER_Z)
                return sbcp_pkg::CODE_UPPER_A
                       + sbcp_pkg::CODE_W'(ch - sbcp_pkg::ASC_UPPER_A);
            case (ch)
                sbcp_pkg::ASC_SPACE:    return sbcp_pkg::CODE_SPACE;
                sbcp_pkg::ASC_COMMA:    return sbcp_pkg::CODE_COMMA;
                sbcp_pkg::ASC_PERIOD:   return sbcp_pkg::CODE_PERIOD;
                sbcp_pkg::ASC_QUESTION: return sbcp_pkg::CODE_QUESTION;
                sbcp_pkg::ASC_BANG:     return sbcp_pkg::CODE_BANG;
                sbcp_pkg::ASC_NEWLINE:  return sbcp_pkg::CODE_NEWLINE;
                default:                return sbcp_pkg::CODE_UNKNOWN;
            endcase
        endfunction

        // one accepted character; queues a word when it fills one or ends the string
        function void note_char(bit [sbcp_pkg::CHAR_W-1:0] ch, bit eos);
            sbcp_pkg::t_word w;
            acc = {acc[sbcp_pkg::WORD_W-sbcp_pkg::CODE_W-1:0], six_bit_code(ch)};
            fill = fill + 1'b1;
            if (fill >= WORD_CHARS || eos) begin
                w.word = acc;
                w.count = fill;
                w.final_word = eos;
                expected_words.push_back(w);
                acc = '0;
                fill = '0;
            end
        endfunction

        function void report(string what, sbcp_pkg::t_word got, sbcp_pkg::t_word want,
                             bit has_want);
            mismatches++;
            if (mismatches <= 10) begin
                if (has_want)
                    $display({"%s: expected word %h count %0d last %0b,",
                              " got word %h count %0d last %0b"},
                             what, want.word, want.count, want.final_word,
                             got.word, got.count, got.final_word);
                else
                    $display("%s: got word %h count %0d last %0b",
                             what, got.word, got.count, got.final_word);
            end
        endfunction

        // one accepted output word against the oldest expectation
        function void check_word(logic [sbcp_pkg::WORD_W-1:0] word,
                                 logic [sbcp_pkg::CNT_W-1:0] count, logic last);
            sbcp_pkg::t_word got;
            sbcp_pkg::t_word want;
            got.word = word;
            got.count = count;
            got.final_word = last;
            if (expected_words.size() == 0) begin
                report("unexpected word", got, got, 1'b0);
                return;
            end
            want = expected_words.pop_front();
            if (got.word !== want.word || got.count !== want.count ||
                got.final_word !== want.final_word)
                report("word mismatch", got, want, 1'b1);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] character
    logic        s_axis_tlast = 1'b0;   // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;          // [59:0] packed_word, [63:60] char_count
    logic        m_axis_tlast;          // final_word

    word_scoreboard packer_sb = new();

    int items_sent = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_stall = 0;

    // 4 ns period
    always #2 i_clk = ~i_clk;

    six_bit_char_packer #(
        .CHARS_PER_WORD(WORD_CHARS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // offer one character, with an optional gap before it, and wait until it is taken
    task automatic send_char(input bit [7:0] ch, input bit eos);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tlast <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        packer_sb.note_char(ch, eos);
        items_sent++;
    endtask

    // mostly letters and punctuation, the rest any byte at all
    function automatic bit [7:0] random_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sbcp_pkg::ASC_LOWER_A + 8'($urandom_range(0, 25));
            4, 5:       return sbcp_pkg::ASC_UPPER_A + 8'($urandom_range(0, 25));
            6: begin
                case ($urandom_range(0, 5))
                    0:       return sbcp_pkg::ASC_SPACE;
                    1:       return sbcp_pkg::ASC_COMMA;
                    2:       return sbcp_pkg::ASC_PERIOD;
                    3:       return sbcp_pkg::ASC_QUESTION;
                    4:       return sbcp_pkg::ASC_BANG;
                    default: return sbcp_pkg::ASC_NEWLINE;
                endcase
            end
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sink side: check each accepted word, then decide whether to stall next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            packer_sb.check_word(m_axis_tdata[59:0], m_axis_tdata[63:60], m_axis_tlast);
        if (rx_stall > 0) begin
            rx_stall--;
            if (rx_stall == 0)
                m_axis_tready <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(1, 18);
            m_axis_tready <= 1'b0;
        end
    end

    // generous cap on the whole run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        // directed text: every punctuation code, both ends of each letter range, byte
        // extremes and neighbors of the letter ranges; a full word closed by the end
        // mark, a full word without it, then a one-character string
        bit [7:0] directed_text [21] = '{
            8'h61, 8'h5a, 8'h20, 8'h2c, 8'h2e, 8'h3f, 8'h21, 8'h0a, 8'h00, 8'hff,
            8'h7a, 8'h41, 8'h80, 8'h7f, 8'h60, 8'h7b, 8'h40, 8'h5b, 8'h62, 8'h63,
            8'h51
        };
        int str_len;
        bit with_end;
        int k;
        int drain;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (k = 0; k < 21; k++)
            send_char(directed_text[k], k == 9 || k == 20);

        // random strings; some run past several words without an end mark
        while (items_sent < LAST_ITEMS) begin
            if (items_sent >= CALM_AFTER) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            with_end = $urandom_range(0, 7) != 0;
            str_len = with_end ? $urandom_range(1, 24) : $urandom_range(10, 40);
            for (k = 1; k <= str_len; k++)
                send_char(random_char(), with_end && k == str_len);
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding words, then let the pipeline settle
        drain = 0;
        while (packer_sb.pending() > 0 && drain < DRAIN_MAX) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (packer_sb.pending() > 0) begin
            $display("%0d expected words never arrived", packer_sb.pending());
            packer_sb.mismatches += packer_sb.pending();
        end

        if (packer_sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sbcp_pkg.sv
rtl/core/sbcp_accum.sv
rtl/core/six_bit_char_packer.sv
tb/six_bit_char_packer_tb.sv
